### hdl/ffac_pkg.sv
// Package for the first-fit allocator: width constants, op and status codes.
// No dependencies.
`timescale 1ns / 1ps
package ffac_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ADDR_BITS_DEF    = 16;
    localparam int PID_W            = 16;
    localparam int SIZE_IN_W        = 17;
    localparam int CNT_OUT_W        = 7;
    localparam int STATUS_W         = 3;
    localparam int OP_W             = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OK_COMPACT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PID_EXISTS = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PID_ABSENT = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd6;

endpackage

### hdl/ffac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ffac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/first_fit_allocator_compaction.sv
// First-fit allocator top level: sequencer over the segment table memory.
// Depends on ffac_pkg and ffac_ram.
// Query and rejected sizes go straight from idle to the result stage; allocate/free
//   walk the N segments (pid scan, first-fit scan, optional compaction walk and retry,
//   shift or merge walk), reading each memory entry through the single read port.
// One item at a time; the result register lets the next item be accepted
// while the previous result waits. Reset: one hole of 65535 bytes, no processes.
`timescale 1ns / 1ps
module first_fit_allocator_compaction #(
    parameter int MAX_SEGMENTS = ffac_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = ffac_pkg::ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [15:0]                       cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ffac_pkg::OP_W-1:0]         op,
    input  logic [ffac_pkg::PID_W-1:0]        pid,
    input  logic signed [ffac_pkg::SIZE_IN_W-1:0] alloc_size,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ffac_pkg::STATUS_W-1:0]     status,
    output logic [15:0]                       start_address,
    output logic [15:0]                       free_bytes,
    output logic [15:0]                       used_bytes,
    output logic [ffac_pkg::CNT_OUT_W-1:0]    hole_count,
    output logic [ffac_pkg::CNT_OUT_W-1:0]    process_count
);
    import ffac_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = ADDR_BITS;
    localparam int EW = 1 + PID_W + 2 * AW;

    typedef struct packed {
        logic             hole;
        logic [PID_W-1:0] pid;
        logic [AW-1:0]    start;
        logic [AW-1:0]    size;
    } seg_t;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_PIDRD   = 13'b0000000000010,
        S_PIDCHK  = 13'b0000000000100,
        S_FITRD   = 13'b0000000001000,
        S_FITCHK  = 13'b0000000010000,
        S_SHIFT   = 13'b0000000100000,
        S_SHIFTW  = 13'b0000001000000,
        S_CMP     = 13'b0000010000000,
        S_CMPCHK  = 13'b0000100000000,
        S_MRG     = 13'b0001000000000,
        S_MRGCHK  = 13'b0010000000000,
        S_DONE    = 13'b0100000000000,
        S_CLEAR   = 13'b1000000000000
    } state_t;

    state_t state_reg;

    // memory
    logic          we;
    logic [IW-1:0] waddr, raddr;
    seg_t          wdata, rdata;

    ffac_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic [AW-1:0] msize_reg, free_reg, used_reg;
    logic [CW-1:0] segcnt_reg, holes_reg, procs_reg;
    logic [OP_W-1:0] op_reg;
    logic [PID_W-1:0] pid_reg;
    logic [AW-1:0] sz_reg;
    logic [CW-1:0] r_reg, w_reg;   // read and write walkers
    logic [IW-1:0] hit_reg;        // index of found process / hole
    logic          retry_reg;      // allocate after compaction
    logic [AW-1:0] addr_reg;       // compaction running address
    seg_t          carry_reg;      // entry carried by shift or merge
    logic          carry_vld_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [AW-1:0] sa_reg;
    logic          ov_reg;
    logic [STATUS_W-1:0] ost_reg;
    logic [15:0]   osa_reg;
    logic [15:0]   ofree_reg, oused_reg;
    logic [CNT_OUT_W-1:0] oholes_reg, oprocs_reg;
    logic          pend_reg;       // entry 0 needs init write

    assign in_ready = (state_reg == S_IDLE) && !pend_reg;
    assign out_valid = ov_reg;
    assign status = ost_reg;
    assign start_address = osa_reg;
    assign free_bytes = ofree_reg;
    assign used_bytes = oused_reg;
    assign hole_count = oholes_reg;
    assign process_count = oprocs_reg;

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    logic [SIZE_IN_W-1:0] raw;
    assign raw = alloc_size;

    logic r_last;
    assign r_last = (r_reg >= segcnt_reg);

    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = r_reg[IW-1:0];
        if (pend_reg)
        begin
            we = (msize_reg != '0);
            waddr = '0;
            wdata = '{hole: 1'b1, pid: '0, start: '0, size: msize_reg};
        end
        unique case (state_reg)
            S_FITCHK:
            begin
                if (rdata.hole && rdata.size == sz_reg && !r_last)
                begin
                    we = 1'b1;
                    waddr = r_reg[IW-1:0];
                    wdata = '{hole: 1'b0, pid: pid_reg, start: rdata.start, size: rdata.size};
                end
            end
            S_SHIFTW:
            begin
                // above the split point move entry w-1 up, else write the carried entry
                we = 1'b1;
                waddr = w_reg[IW-1:0];
                wdata = (w_reg > CW'(hit_reg) + CW'(1)) ? rdata : carry_reg;
            end
            S_CMPCHK:
            begin
                if (!r_last && !rdata.hole)
                begin
                    we = 1'b1;
                    waddr = w_reg[IW-1:0];
                    wdata = '{hole: 1'b0, pid: rdata.pid, start: addr_reg, size: rdata.size};
                end
                else if (r_last && free_reg != '0 && w_reg < CW'(MAX_SEGMENTS))
                begin
                    we = 1'b1;
                    waddr = w_reg[IW-1:0];
                    wdata = '{hole: 1'b1, pid: '0, start: addr_reg, size: free_reg};
                end
            end
            S_MRGCHK:
            begin
                if (carry_vld_reg && (r_last || !(carry_reg.hole
                    && (rdata.hole || r_reg[IW-1:0] == hit_reg))))
                begin
                    we = 1'b1;
                    waddr = w_reg[IW-1:0];
                    wdata = carry_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            msize_reg <= AW'(16'hFFFF);
            free_reg <= AW'(16'hFFFF);
            used_reg <= '0;
            segcnt_reg <= CW'(1);
            holes_reg <= CW'(1);
            procs_reg <= '0;
            pend_reg <= 1'b1;
            ov_reg <= 1'b0;
            r_reg <= '0;
            w_reg <= '0;
            retry_reg <= 1'b0;
            carry_vld_reg <= 1'b0;
        end
        else
        begin
            if (pend_reg)
            begin
                pend_reg <= 1'b0;
            end
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                msize_reg <= AW'(cfg_wdata);
                free_reg <= AW'(cfg_wdata);
                used_reg <= '0;
                procs_reg <= '0;
                segcnt_reg <= (AW'(cfg_wdata) != '0) ? CW'(1) : '0;
                holes_reg <= (AW'(cfg_wdata) != '0) ? CW'(1) : '0;
                pend_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        op_reg <= op;
                        pid_reg <= pid;
                        sz_reg <= raw[AW-1:0];
                        sa_reg <= '0;
                        retry_reg <= 1'b0;
                        r_reg <= '0;
                        if (op == OP_ALLOC)
                        begin
                            if (raw == '0 || raw[SIZE_IN_W-1])
                            begin
                                st_reg <= ST_BAD_SIZE;
                                state_reg <= S_DONE;
                            end
                            else if ({1'b0, raw} > (SIZE_IN_W+1)'(free_reg))
                            begin
                                st_reg <= ST_NO_SPACE;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_PIDRD;
                            end
                        end
                        else if (op == OP_FREE)
                        begin
                            state_reg <= S_PIDRD;
                        end
                        else
                        begin
                            st_reg <= ST_OK;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_PIDRD:
                begin
                    r_reg <= r_reg;
                    state_reg <= S_PIDCHK;
                end
                S_PIDCHK:
                begin
                    if (r_last)
                    begin
                        r_reg <= '0;
                        if (op_reg == OP_ALLOC)
                        begin
                            state_reg <= S_FITRD;
                        end
                        else
                        begin
                            st_reg <= ST_PID_ABSENT;
                            state_reg <= S_DONE;
                        end
                    end
                    else if (!rdata.hole && rdata.pid == pid_reg)
                    begin
                        if (op_reg == OP_ALLOC)
                        begin
                            st_reg <= ST_PID_EXISTS;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            // free: adjust counters, then merge walk from 0
                            hit_reg <= r_reg[IW-1:0];
                            free_reg <= free_reg + rdata.size;
                            used_reg <= used_reg - rdata.size;
                            holes_reg <= holes_reg + CW'(1);
                            if (procs_reg != '0)
                            begin
                                procs_reg <= procs_reg - CW'(1);
                            end
                            st_reg <= ST_OK;
                            r_reg <= '0;
                            w_reg <= '0;
                            carry_vld_reg <= 1'b0;
                            state_reg <= S_MRG;
                        end
                    end
                    else
                    begin
                        r_reg <= r_reg + CW'(1);
                        state_reg <= S_PIDRD;
                    end
                end
                S_FITRD:
                begin
                    state_reg <= S_FITCHK;
                end
                S_FITCHK:
                begin
                    if (r_last)
                    begin
                        if (retry_reg)
                        begin
                            st_reg <= ST_NO_SPACE;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            retry_reg <= 1'b1;
                            r_reg <= '0;
                            w_reg <= '0;
                            addr_reg <= '0;
                            state_reg <= S_CMP;
                        end
                    end
                    else if (rdata.hole && rdata.size >= sz_reg)
                    begin
                        st_reg <= retry_reg ? ST_OK_COMPACT : ST_OK;
                        if (rdata.size == sz_reg)
                        begin
                            if (holes_reg != '0)
                            begin
                                holes_reg <= holes_reg - CW'(1);
                            end
                            free_reg <= free_reg - sz_reg;
                            used_reg <= used_reg + sz_reg;
                            procs_reg <= procs_reg + CW'(1);
                            sa_reg <= rdata.start;
                            state_reg <= S_DONE;
                        end
                        else if (segcnt_reg >= CW'(MAX_SEGMENTS))
                        begin
                            st_reg <= ST_TABLE_FULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            // shift walk from the top down to r+1
                            hit_reg <= r_reg[IW-1:0];
                            carry_reg <= '{hole: 1'b1, pid: '0,
                                           start: rdata.start + sz_reg,
                                           size: rdata.size - sz_reg};
                            sa_reg <= rdata.start;
                            w_reg <= segcnt_reg;
                            r_reg <= segcnt_reg - CW'(1);
                            state_reg <= S_SHIFT;
                        end
                    end
                    else
                    begin
                        r_reg <= r_reg + CW'(1);
                        state_reg <= S_FITRD;
                    end
                end
                S_SHIFT:
                begin
                    // rdata is entry r (=w-1) by S_SHIFTW, as the read is registered; entry
                    // hit is rewritten last as the process region
                    state_reg <= S_SHIFTW;
                end
                S_SHIFTW:
                begin
                    if (w_reg == CW'(hit_reg) + CW'(1))
                    begin
                        // the new hole is now in place; write the process entry
                        w_reg <= CW'(hit_reg);
                        carry_reg <= '{hole: 1'b0, pid: pid_reg, start: sa_reg, size: sz_reg};
                        r_reg <= CW'(hit_reg);
                        state_reg <= S_SHIFT;
                    end
                    else if (w_reg == CW'(hit_reg))
                    begin
                        segcnt_reg <= segcnt_reg + CW'(1);
                        free_reg <= free_reg - sz_reg;
                        used_reg <= used_reg + sz_reg;
                        procs_reg <= procs_reg + CW'(1);
                        holes_reg <= holes_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        // entry w-1 moved up; fetch the one below it
                        w_reg <= w_reg - CW'(1);
                        r_reg <= w_reg - CW'(2);
                        state_reg <= S_SHIFT;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_CMPCHK;
                end
                S_CMPCHK:
                begin
                    if (r_last)
                    begin
                        if (free_reg != '0 && w_reg < CW'(MAX_SEGMENTS))
                        begin
                            segcnt_reg <= w_reg + CW'(1);
                            holes_reg <= CW'(1);
                        end
                        else
                        begin
                            segcnt_reg <= w_reg;
                            holes_reg <= '0;
                        end
                        r_reg <= '0;
                        state_reg <= S_FITRD;
                    end
                    else
                    begin
                        if (!rdata.hole)
                        begin
                            w_reg <= w_reg + CW'(1);
                            addr_reg <= addr_reg + rdata.size;
                        end
                        r_reg <= r_reg + CW'(1);
                        state_reg <= S_CMP;
                    end
                end
                S_MRG:
                begin
                    state_reg <= S_MRGCHK;
                end
                S_MRGCHK:
                begin
                    if (r_last)
                    begin
                        segcnt_reg <= carry_vld_reg ? w_reg + CW'(1) : w_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (carry_vld_reg && carry_reg.hole
                            && (rdata.hole || r_reg[IW-1:0] == hit_reg))
                        begin
                            carry_reg.size <= carry_reg.size + rdata.size;
                            if (holes_reg != '0)
                            begin
                                holes_reg <= holes_reg - CW'(1);
                            end
                        end
                        else
                        begin
                            if (carry_vld_reg)
                            begin
                                w_reg <= w_reg + CW'(1);
                            end
                            carry_reg <= rdata;
                            if (r_reg[IW-1:0] == hit_reg)
                            begin
                                carry_reg <= '{hole: 1'b1, pid: '0,
                                               start: rdata.start, size: rdata.size};
                            end
                            carry_vld_reg <= 1'b1;
                        end
                        r_reg <= r_reg + CW'(1);
                        state_reg <= S_MRG;
                    end
                end
                S_DONE:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg <= 1'b1;
                        ost_reg <= st_reg;
                        osa_reg <= (st_reg == ST_OK || st_reg == ST_OK_COMPACT)
                                   ? 16'(sa_reg) : 16'd0;
                        ofree_reg <= 16'(free_reg);
                        oused_reg <= 16'(used_reg);
                        oholes_reg <= CNT_OUT_W'(holes_reg);
                        oprocs_reg <= CNT_OUT_W'(procs_reg);
                        state_reg <= S_IDLE;
                    end
                end
                S_CLEAR:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> state_reg != S_IDLE)
        else $error("accepted item left the sequencer idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        segcnt_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count above table depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg)
        else $error("result dropped while stalled");

endmodule
